@@ design/sorted_insertion_queue_defines.svh @@
// assertion macros used by the queue design file
`ifndef SORTED_INSERTION_QUEUE_DEFINES_SVH
`define SORTED_INSERTION_QUEUE_DEFINES_SVH

// property checked while reset is low
`define SIQ_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("sorted insertion queue assertion failed");

// property checked at every edge, reset included
`define SIQ_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("sorted insertion queue assertion failed");

`endif

@@ design/siq_pkg.sv @@
package siq_pkg;

   localparam int DEPTH_DEF     = 16;
   localparam int KEY_WIDTH_DEF = 32;

   localparam int CMD_W    = 2;
   localparam int AMOUNT_W = 5;
   localparam int CAP_W    = 5;
   localparam int CSR_W    = 5;
   localparam int CSR_IDX_W = 1;

   localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
   localparam logic [CMD_W-1:0] CMD_POP    = 2'd1;
   localparam logic [CMD_W-1:0] CMD_DROP   = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_CAPACITY_LIMIT  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SORT_DESCENDING = 1'd1;

   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SCAN_CHK,
      ST_SHIFT,
      ST_SHIFT_WR,
      ST_POP_CHK,
      ST_HEAD,
      ST_RESP
   } state_type;

endpackage

@@ design/sorted_insertion_queue.sv @@
// channel    ports                                  handshake
// request    req_cmd, req_key, req_amount           start high while busy low
// result     rsp_ok, rsp_popped_key, rsp_head_*,    rsp_valid strobe, one cycle
//            rsp_fill
// config     csr_index, csr_wdata                   csr_we, taken at once
//
// one transaction at a time; the key memory has one read and one write port
// insert: forward search, then tail shift, one memory read per step, with the
//   read data registered inside the memory
// pop: ST_POP_CHK, ST_HEAD, ST_RESP; drop and refused operations: ST_HEAD, ST_RESP
// reset clears fill and head pointer, presets the CSRs; key memory not cleared
// the receiver cannot stall: the result strobe lasts one cycle
`include "sorted_insertion_queue_defines.svh"

module sorted_insertion_queue #(
   parameter int DEPTH     = siq_pkg::DEPTH_DEF,
   parameter int KEY_WIDTH = siq_pkg::KEY_WIDTH_DEF,
   localparam int AW   = $clog2(DEPTH),
   localparam int CW   = $clog2(DEPTH + 1)
) (
   input  logic                          clock,
   input  logic                          reset,
   // request
   input  logic                          start,
   output logic                          busy,
   input  logic [siq_pkg::CMD_W-1:0]     req_cmd,
   input  logic [KEY_WIDTH-1:0]          req_key,
   input  logic [siq_pkg::AMOUNT_W-1:0]  req_amount,
   // result
   output logic                          rsp_valid,
   output logic                          rsp_ok,
   output logic [KEY_WIDTH-1:0]          rsp_popped_key,
   output logic                          rsp_head_valid,
   output logic [KEY_WIDTH-1:0]          rsp_head_key,
   output logic [CW-1:0]                 rsp_fill,
   // configuration
   input  logic                          csr_we,
   input  logic [siq_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [siq_pkg::CSR_W-1:0]     csr_wdata
);

   // physical address math runs one bit wider than the index
   localparam int PW   = AW + 1;
   // width for comparing fill against the 5 bit fields
   localparam int CMPW = (CW > siq_pkg::CAP_W) ? CW : siq_pkg::CAP_W;

   siq_pkg::state_type state_ff, state_in;

   logic [CW-1:0]                 fill_ff, fill_in;
   logic [AW-1:0]                 head_ff, head_in;   // physical slot of the head
   logic [CW-1:0]                 idx_ff, idx_in;     // logical scan / shift position
   logic [CW-1:0]                 pos_ff, pos_in;     // logical insert position
   logic [siq_pkg::CMD_W-1:0]     cmd_ff, cmd_in;
   logic [KEY_WIDTH-1:0]          key_ff, key_in;
   logic [siq_pkg::AMOUNT_W-1:0]  amount_ff, amount_in;
   logic                          ok_ff, ok_in;
   logic [KEY_WIDTH-1:0]          popped_ff, popped_in;
   logic [siq_pkg::CAP_W-1:0]     cap_ff;
   logic                          desc_ff;

   // memory port
   logic                 rd_en;
   logic [AW-1:0]        rd_addr;
   logic [KEY_WIDTH-1:0] rd_data;
   logic                 wr_en;
   logic [AW-1:0]        wr_addr;
   logic [KEY_WIDTH-1:0] wr_data;

   logic           accept;
   logic [CMPW-1:0] fill_x;
   logic [CMPW-1:0] limit_x;
   logic [CMPW-1:0] cap_x;
   logic [CMPW-1:0] amount_x;
   logic           goes_after;

   // logical position to physical slot, wrapping around the ring
   function automatic logic [AW-1:0] to_phys(input logic [AW-1:0] head,
                                             input logic [CW-1:0] logical);
      logic [PW-1:0] sum;
      sum = PW'(head) + PW'(logical);
      if (sum >= PW'(DEPTH)) begin
         sum = sum - PW'(DEPTH);
      end
      return sum[AW-1:0];
   endfunction

   assign accept   = start && !busy;
   assign fill_x   = CMPW'(fill_ff);
   assign cap_x    = CMPW'(cap_ff);
   assign amount_x = CMPW'(req_amount);
   // a limit above the memory depth acts as the depth
   assign limit_x  = (cap_x > CMPW'(DEPTH)) ? CMPW'(DEPTH) : cap_x;

   // new key must stay behind the stored key just read
   assign goes_after = desc_ff ? (key_ff < rd_data) : (key_ff > rd_data);

   siq_ram #(
      .WIDTH (KEY_WIDTH),
      .DEPTH (DEPTH)
   ) u_key_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff  <= siq_pkg::CAP_RESET;
         desc_ff <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            siq_pkg::CSR_CAPACITY_LIMIT:  cap_ff  <= csr_wdata[siq_pkg::CAP_W-1:0];
            siq_pkg::CSR_SORT_DESCENDING: desc_ff <= csr_wdata[0];
         endcase
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= siq_pkg::ST_IDLE;
         fill_ff  <= '0;
         head_ff  <= '0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         head_ff  <= head_in;
      end
   end

   // transaction payload, no reset needed
   always_ff @(posedge clock) begin
      idx_ff    <= idx_in;
      pos_ff    <= pos_in;
      cmd_ff    <= cmd_in;
      key_ff    <= key_in;
      amount_ff <= amount_in;
      ok_ff     <= ok_in;
      popped_ff <= popped_in;
   end

   always_comb begin
      state_in  = state_ff;
      fill_in   = fill_ff;
      head_in   = head_ff;
      idx_in    = idx_ff;
      pos_in    = pos_ff;
      cmd_in    = cmd_ff;
      key_in    = key_ff;
      amount_in = amount_ff;
      ok_in     = ok_ff;
      popped_in = popped_ff;
      rd_en     = 1'b0;
      rd_addr   = to_phys(head_ff, '0);
      wr_en     = 1'b0;
      wr_addr   = to_phys(head_ff, '0);
      wr_data   = key_ff;

      unique case (state_ff)
         siq_pkg::ST_IDLE: begin
            if (accept) begin
               cmd_in    = req_cmd;
               key_in    = req_key;
               amount_in = req_amount;
               ok_in     = 1'b0;
               popped_in = '0;
               state_in  = siq_pkg::ST_HEAD;
               unique case (req_cmd)
                  siq_pkg::CMD_INSERT: begin
                     if (fill_x < limit_x) begin
                        ok_in    = 1'b1;
                        idx_in   = '0;
                        state_in = siq_pkg::ST_SCAN;
                     end
                  end
                  siq_pkg::CMD_POP: begin
                     if (fill_ff != '0) begin
                        // fetch the head key to hand back
                        ok_in    = 1'b1;
                        rd_en    = 1'b1;
                        state_in = siq_pkg::ST_POP_CHK;
                     end
                  end
                  siq_pkg::CMD_DROP: begin
                     if (amount_x != '0 && amount_x <= fill_x) begin
                        // drop is just a head pointer move
                        ok_in   = 1'b1;
                        head_in = to_phys(head_ff, CW'(req_amount));
                        fill_in = fill_ff - CW'(req_amount);
                     end
                  end
                  default: begin
                     // unused command reports state only
                  end
               endcase
            end
         end
         siq_pkg::ST_POP_CHK: begin
            popped_in = rd_data;
            head_in   = to_phys(head_ff, CW'(1));
            fill_in   = fill_ff - CW'(1);
            state_in  = siq_pkg::ST_HEAD;
         end
         siq_pkg::ST_SCAN: begin
            // forward search for the first key the new one goes ahead of
            if (idx_ff == fill_ff) begin
               pos_in   = fill_ff;
               idx_in   = fill_ff;
               state_in = siq_pkg::ST_SHIFT;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = to_phys(head_ff, idx_ff);
               state_in = siq_pkg::ST_SCAN_CHK;
            end
         end
         siq_pkg::ST_SCAN_CHK: begin
            if (goes_after) begin
               idx_in   = idx_ff + CW'(1);
               state_in = siq_pkg::ST_SCAN;
            end else begin
               pos_in   = idx_ff;
               idx_in   = fill_ff;
               state_in = siq_pkg::ST_SHIFT;
            end
         end
         siq_pkg::ST_SHIFT: begin
            // move the tail back one slot, last entry first
            if (idx_ff == pos_ff) begin
               wr_en    = 1'b1;
               wr_addr  = to_phys(head_ff, pos_ff);
               wr_data  = key_ff;
               fill_in  = fill_ff + CW'(1);
               state_in = siq_pkg::ST_HEAD;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = to_phys(head_ff, idx_ff - CW'(1));
               state_in = siq_pkg::ST_SHIFT_WR;
            end
         end
         siq_pkg::ST_SHIFT_WR: begin
            // read and write slots never coincide, so no forwarding needed
            wr_en    = 1'b1;
            wr_addr  = to_phys(head_ff, idx_ff);
            wr_data  = rd_data;
            idx_in   = idx_ff - CW'(1);
            state_in = siq_pkg::ST_SHIFT;
         end
         siq_pkg::ST_HEAD: begin
            // fetch the head after all writes of this transaction landed
            rd_en    = (fill_ff != '0);
            state_in = siq_pkg::ST_RESP;
         end
         siq_pkg::ST_RESP: begin
            state_in = siq_pkg::ST_IDLE;
         end
         default: begin
            state_in = siq_pkg::ST_IDLE;
         end
      endcase
   end

   assign busy           = (state_ff != siq_pkg::ST_IDLE);
   assign rsp_valid      = (state_ff == siq_pkg::ST_RESP);
   assign rsp_ok         = ok_ff;
   assign rsp_popped_key = popped_ff;
   assign rsp_head_valid = (fill_ff != '0);
   assign rsp_head_key   = (fill_ff != '0) ? rd_data : '0;
   assign rsp_fill       = fill_ff;

   `SIQ_ASSERT(a_fill_in_range, clock, reset, fill_ff <= CW'(DEPTH))
   `SIQ_ASSERT(a_idle_after_rsp, clock, reset, rsp_valid |=> !busy)
   `SIQ_ASSERT(a_busy_after_accept, clock, reset, (start && !busy) |=> busy)
   `SIQ_ASSERT(a_no_rw_collision, clock, reset, !(wr_en && rd_en && wr_addr == rd_addr))
   `SIQ_ASSERT_ALWAYS(a_idle_out_of_reset, clock, $past(reset) |-> !busy)

endmodule

@@ design/siq_ram.sv @@
module siq_ram #(
   parameter int WIDTH = siq_pkg::KEY_WIDTH_DEF,
   parameter int DEPTH = siq_pkg::DEPTH_DEF,
   localparam int AW   = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ tb/sv/sorted_insertion_queue_test.sv @@
module sorted_insertion_queue_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int QDEPTH = 16;
   localparam int WATCHDOG_LIMIT = 20000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [siq_pkg::CMD_W-1:0] req_cmd = siq_pkg::CMD_INSERT;
   logic [31:0] req_key = '0;
   logic [siq_pkg::AMOUNT_W-1:0] req_amount = '0;
   logic rsp_valid, rsp_ok, rsp_head_valid;
   logic [31:0] rsp_popped_key, rsp_head_key;
   logic [4:0] rsp_fill;
   logic csr_we = 1'b0;
   logic [siq_pkg::CSR_IDX_W-1:0] csr_index = siq_pkg::CSR_CAPACITY_LIMIT;
   logic [siq_pkg::CSR_W-1:0] csr_wdata = '0;

   sorted_insertion_queue uut (.*);

   always #4 clock = ~clock;

   // one result transaction
   typedef struct packed {
      logic ok;
      logic [31:0] popped_key;
      logic head_valid;
      logic [31:0] head_key;
      logic [4:0] fill;
   } outcome_type;

   // shadow of the queue contents and registers
   logic [31:0] shadow_keys[QDEPTH];
   int shadow_fill;
   int shadow_cap;
   bit shadow_desc;

   outcome_type pending_outcomes[$];
   int failures;
   int idle_cycles;
   int send_gap_pct;

   // computes the outcome of one command and updates the shadow queue
   function automatic outcome_type apply_command(logic [siq_pkg::CMD_W-1:0] cmd,
                                                 logic [31:0] k,
                                                 logic [siq_pkg::AMOUNT_W-1:0] amt);
      outcome_type o;
      int lim, pos;
      o = '0;
      if (cmd == siq_pkg::CMD_INSERT) begin
         lim = (shadow_cap > QDEPTH) ? QDEPTH : shadow_cap;
         if (shadow_fill < lim) begin
            pos = 0;
            // skip stored keys that strictly precede the new one
            while (pos < shadow_fill &&
                   (shadow_desc ? (k < shadow_keys[pos]) : (k > shadow_keys[pos])))
               pos++;
            for (int i = shadow_fill; i > pos; i--) shadow_keys[i] = shadow_keys[i-1];
            shadow_keys[pos] = k;
            shadow_fill++;
            o.ok = 1'b1;
         end
      end else if (cmd == siq_pkg::CMD_POP) begin
         if (shadow_fill > 0) begin
            o.popped_key = shadow_keys[0];
            for (int i = 0; i + 1 < shadow_fill; i++) shadow_keys[i] = shadow_keys[i+1];
            shadow_fill--;
            o.ok = 1'b1;
         end
      end else if (cmd == siq_pkg::CMD_DROP) begin
         if (amt != 0 && amt <= shadow_fill) begin
            for (int i = 0; i + amt < shadow_fill; i++) shadow_keys[i] = shadow_keys[i+amt];
            shadow_fill -= amt;
            o.ok = 1'b1;
         end
      end
      o.head_valid = shadow_fill > 0;
      o.head_key = shadow_fill > 0 ? shadow_keys[0] : 32'd0;
      o.fill = shadow_fill[4:0];
      return o;
   endfunction

   // result checking against the oldest expectation
   always @(posedge clock) begin
      outcome_type want;
      if (!reset && rsp_valid) begin
         idle_cycles <= 0;
         if (pending_outcomes.size() == 0) begin
            $display("%0t: unexpected result ok=%0b fill=%0d", $time, rsp_ok, rsp_fill);
            failures++;
         end else begin
            want = pending_outcomes.pop_front();
            if (rsp_ok !== want.ok) begin
               $display("%0t: ok expected %0b actual %0b", $time, want.ok, rsp_ok);
               failures++;
            end
            if (rsp_popped_key !== want.popped_key) begin
               $display("%0t: popped_key expected %h actual %h", $time,
                        want.popped_key, rsp_popped_key);
               failures++;
            end
            if (rsp_head_valid !== want.head_valid) begin
               $display("%0t: head_valid expected %0b actual %0b", $time,
                        want.head_valid, rsp_head_valid);
               failures++;
            end
            if (rsp_head_key !== want.head_key) begin
               $display("%0t: head_key expected %h actual %h", $time,
                        want.head_key, rsp_head_key);
               failures++;
            end
            if (rsp_fill !== want.fill) begin
               $display("%0t: fill expected %0d actual %0d", $time, want.fill, rsp_fill);
               failures++;
            end
         end
      end else if (!reset && !(start && !busy)) begin
         idle_cycles <= idle_cycles + 1;
      end else begin
         idle_cycles <= 0;
      end
   end

   // watchdog on cycles with neither an accepted transaction nor a result
   always @(posedge clock) begin
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // register write, only while idle
   task automatic write_csr(logic [siq_pkg::CSR_IDX_W-1:0] idx, int value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value[siq_pkg::CSR_W-1:0];
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == siq_pkg::CSR_CAPACITY_LIMIT) shadow_cap = value;
      else shadow_desc = value[0];
      @(posedge clock);
   endtask

   // sends one command; start stays high across back-to-back transactions
   task automatic send_command(logic [siq_pkg::CMD_W-1:0] cmd, logic [31:0] k,
                               logic [siq_pkg::AMOUNT_W-1:0] amt, bit check_typed,
                               outcome_type typed);
      outcome_type o;
      while ($urandom_range(99) < send_gap_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_cmd <= cmd;
      req_key <= k;
      req_amount <= amt;
      @(posedge clock);
      while (busy) @(posedge clock);
      o = apply_command(cmd, k, amt);
      // typed rows must agree with the shadow as well
      if (check_typed && o !== typed) begin
         $display("%0t: table row expected %h predicted %h", $time, typed, o);
         failures++;
      end
      pending_outcomes.push_back(o);
   endtask

   // waits for every result, then lets the block settle
   task automatic drain;
      start <= 1'b0;
      @(posedge clock);
      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // directed table: command, key, amount, typed-in flag, typed outcome
   typedef struct {
      logic [siq_pkg::CMD_W-1:0] cmd;
      logic [31:0] k;
      logic [siq_pkg::AMOUNT_W-1:0] amt;
      bit typed;
      outcome_type want;
   } table_row_type;

   table_row_type directed_rows[] = '{
      // empty queue: pop and drop are refused
      '{siq_pkg::CMD_POP, 32'h0, 5'd0, 1, '{1'b0, 32'h0, 1'b0, 32'h0, 5'd0}},
      '{siq_pkg::CMD_DROP, 32'h0, 5'd1, 1, '{1'b0, 32'h0, 1'b0, 32'h0, 5'd0}},
      '{siq_pkg::CMD_DROP, 32'h0, 5'd0, 1, '{1'b0, 32'h0, 1'b0, 32'h0, 5'd0}},
      '{siq_pkg::CMD_INSERT, 32'hFFFFFFFF, 5'd31, 1,
        '{1'b1, 32'h0, 1'b1, 32'hFFFFFFFF, 5'd1}},
      '{siq_pkg::CMD_INSERT, 32'h0, 5'd0, 1, '{1'b1, 32'h0, 1'b1, 32'h0, 5'd2}},
      '{siq_pkg::CMD_INSERT, 32'h5, 5'd0, 0, '0},
      '{siq_pkg::CMD_INSERT, 32'h5, 5'd0, 0, '0},
      // unused command leaves the queue alone
      '{2'd3, 32'hA5A5A5A5, 5'd31, 1, '{1'b0, 32'h0, 1'b1, 32'h0, 5'd4}},
      '{siq_pkg::CMD_DROP, 32'h0, 5'd5, 1, '{1'b0, 32'h0, 1'b1, 32'h0, 5'd4}},
      '{siq_pkg::CMD_POP, 32'hFFFFFFFF, 5'd31, 1, '{1'b1, 32'h0, 1'b1, 32'h5, 5'd3}},
      '{siq_pkg::CMD_DROP, 32'h0, 5'd2, 1, '{1'b1, 32'h0, 1'b1, 32'hFFFFFFFF, 5'd1}},
      '{siq_pkg::CMD_POP, 32'h0, 5'd0, 1, '{1'b1, 32'hFFFFFFFF, 1'b0, 32'h0, 5'd0}},
      '{siq_pkg::CMD_INSERT, 32'h80000000, 5'd0, 0, '0},
      '{siq_pkg::CMD_INSERT, 32'h7FFFFFFF, 5'd0, 0, '0},
      '{siq_pkg::CMD_DROP, 32'h0, 5'd16, 0, '0},
      '{siq_pkg::CMD_DROP, 32'h0, 5'd2, 0, '0}
   };

   // random command mix, biased toward inserts so the queue fills
   task automatic random_command;
      int pick;
      logic [31:0] k;
      logic [siq_pkg::AMOUNT_W-1:0] amt;
      pick = $urandom_range(99);
      case ($urandom_range(3))
         0: k = $urandom_range(7);
         1: k = $urandom_range(1) ? 32'hFFFFFFFF : 32'h0;
         default: k = $urandom;
      endcase
      amt = $urandom_range(3) == 0 ? 5'($urandom) : 5'($urandom_range(shadow_fill));
      if (pick < 50) send_command(siq_pkg::CMD_INSERT, k, amt, 0, '0);
      else if (pick < 80) send_command(siq_pkg::CMD_POP, k, amt, 0, '0);
      else if (pick < 97) send_command(siq_pkg::CMD_DROP, k, amt, 0, '0);
      else send_command(2'd3, k, amt, 0, '0);
   endtask

   // phase settings: capacity limit, order, sender idle percent
   int phase_cap[] = '{16, 0, 31, 1, 7, 16, 3, 31, 16};
   int phase_desc[] = '{0, 1, 1, 0, 1, 0, 1, 0, 1};
   int phase_gap[] = '{34, 73, 0, 34, 73, 0, 34, 73, 0};

   initial begin
      failures = 0;
      idle_cycles = 0;
      send_gap_pct = 0;
      shadow_fill = 0;
      shadow_cap = siq_pkg::CAP_RESET;
      shadow_desc = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table at reset settings, no idling
      foreach (directed_rows[i])
         send_command(directed_rows[i].cmd, directed_rows[i].k, directed_rows[i].amt,
                      directed_rows[i].typed, directed_rows[i].want);
      // sender waits for every outstanding result
      drain();

      // random phases, each with its own register settings
      foreach (phase_cap[p]) begin
         write_csr(siq_pkg::CSR_CAPACITY_LIMIT, phase_cap[p]);
         write_csr(siq_pkg::CSR_SORT_DESCENDING, phase_desc[p]);
         send_gap_pct = phase_gap[p];
         repeat (150) random_command();
         drain();
      end

      if (failures == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end
endmodule

@@ files.f @@
+incdir+design
design/siq_pkg.sv
design/siq_ram.sv
design/sorted_insertion_queue.sv
tb/sv/sorted_insertion_queue_test.sv
